// ===== rtl/mbrd_pkg.sv =====
// Package for the Modbus RTU request deframer: word types, codes and CRC step.
// Used by mbrd_core and modbus_rtu_request_deframer_top; no dependencies.
package mbrd_pkg;

    // Request type codes
    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_SILENCE = 2'd2;

    // Result status codes
    localparam logic ST_GOOD    = 1'b0;
    localparam logic ST_CRC_ERR = 1'b1;

    // Frame geometry
    localparam int          FRAME_BYTES   = 8;
    localparam int          STORED_BYTES  = FRAME_BYTES - 2;
    localparam logic [3:0]  LEN_NORMAL    = 4'(FRAME_BYTES);
    localparam logic [3:0]  LEN_EXCEPTION = 4'd5;

    // CRC-16/MODBUS constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] AGE_MAX  = 16'hFFFF;
    localparam int          EXC_BIT  = 7;

    localparam logic [15:0] GAP_LIMIT_RESET = 16'd50;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] byte_value;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [7:0]  station;
        logic [7:0]  function_code;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [3:0]  frame_length;
    } t_out_word;

    // Fold one byte into the reflected CRC, one bit per step
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/modbus_rtu_request_deframer_top.sv =====
// Modbus RTU request deframer, top level: config register and result skid.
// Result words are registered into the output register, or the skid stage if blocked.
// Throughput: one input word per cycle while not stalled; the CRC byte step sets the path.
// Input stalls only while both the output register and skid stage hold words.
// Reset (synchronous, active low): empty frame, CRC 0xFFFF, gap limit 50.
// Depends on mbrd_pkg and mbrd_core.
module modbus_rtu_request_deframer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mbrd_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mbrd_pkg::t_out_word o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    import mbrd_pkg::*;

    logic [15:0] r_gap_limit;
    logic        r_out_valid;
    t_out_word   r_out;
    logic        r_skid_valid;
    t_out_word   r_skid;

    logic        in_accept;
    logic        push;
    logic        pop;
    t_out_word   res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign pop         = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    mbrd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .i_gap_limit (r_gap_limit),
        .o_res_valid (push),
        .o_res       (res)
    );

    // Gap limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= GAP_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gap_limit <= i_cfg_data;
        end
    end

    // Output register and skid stage: drain skid first, park when blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    // A parked word always sits behind a held one
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without output word");

    // A result only comes from an accepted byte
    a_result_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (in_accept && (i_in_data.req_type == REQ_BYTE)))
        else $error("result without accepted byte");

    // A blocked result must be parked, not lost
    a_park_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("blocked result not parked");

endmodule

// ===== rtl/mbrd_core.sv =====
// Frame assembly core: byte store, running CRC, frame age and result build.
// Depends on mbrd_pkg.
module mbrd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  mbrd_pkg::t_in_word  i_item,
    input  logic [15:0]       i_gap_limit,
    output logic              o_res_valid,
    output mbrd_pkg::t_out_word o_res
);
    import mbrd_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic [3:0]  r_held, n_held;
    logic [15:0] r_age, n_age;
    logic [7:0]  r_bytes [STORED_BYTES];

    logic [15:0] crc_next;
    logic [3:0]  held_inc;
    logic [7:0]  fc_now;
    logic [3:0]  need;
    logic        frame_done;
    logic        is_byte;

    assign is_byte  = i_accept && (i_item.req_type == REQ_BYTE);
    assign crc_next = crc_byte(r_crc, i_item.byte_value);
    assign held_inc = r_held + 4'd1;
    // Function code is the incoming byte when it is the second of the frame
    assign fc_now   = (r_held == 4'd1) ? i_item.byte_value : r_bytes[1];
    assign need     = fc_now[EXC_BIT] ? LEN_EXCEPTION : LEN_NORMAL;
    assign frame_done = is_byte && (held_inc >= 4'd2) && (held_inc >= need);

    // Next-state logic for CRC, count and age
    always_comb begin
        n_crc  = r_crc;
        n_held = r_held;
        n_age  = r_age;
        if (i_accept) begin
            case (i_item.req_type)
                REQ_BYTE: begin
                    if (frame_done) begin
                        n_crc  = CRC_INIT;
                        n_held = 4'd0;
                        n_age  = 16'd0;
                    end else begin
                        n_crc  = crc_next;
                        n_held = held_inc;
                        if (r_held == 4'd0) begin
                            n_age = 16'd0;
                        end
                    end
                end
                REQ_TICK: begin
                    if ((r_held != 4'd0) && (r_age != AGE_MAX)) begin
                        n_age = r_age + 16'd1;
                    end
                end
                REQ_SILENCE: begin
                    if ((r_held != 4'd0) && (r_age > i_gap_limit)) begin
                        n_crc  = CRC_INIT;
                        n_held = 4'd0;
                        n_age  = 16'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Build the result word for a completed frame
    always_comb begin
        o_res_valid = frame_done;
        o_res       = '0;
        o_res.frame_length = need;
        if (crc_next == 16'd0) begin
            o_res.status        = ST_GOOD;
            o_res.station       = r_bytes[0];
            o_res.function_code = fc_now;
            if (fc_now[EXC_BIT]) begin
                o_res.first_word  = {8'h00, r_bytes[2]};
                o_res.second_word = 16'd0;
            end else begin
                o_res.first_word  = {r_bytes[2], r_bytes[3]};
                o_res.second_word = {r_bytes[4], r_bytes[5]};
            end
        end else begin
            o_res.status = ST_CRC_ERR;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_held <= 4'd0;
            r_age  <= 16'd0;
        end else begin
            r_crc  <= n_crc;
            r_held <= n_held;
            r_age  <= n_age;
        end
    end

    // Store the first bytes of the frame
    always_ff @(posedge i_clk) begin
        if (is_byte && (r_held < 4'(STORED_BYTES))) begin
            r_bytes[r_held[2:0]] <= i_item.byte_value;
        end
    end

endmodule
